>>> sv/pia_pkg.sv
`timescale 1ns / 1ps
package pia_pkg;

  typedef enum logic [4:0] {
    OP_ADD_B    = 5'd0,
    OP_ADD_W    = 5'd1,
    OP_ADD_D    = 5'd2,
    OP_ADD_Q    = 5'd3,
    OP_SUB_B    = 5'd4,
    OP_SUB_W    = 5'd5,
    OP_SUB_D    = 5'd6,
    OP_SUB_Q    = 5'd7,
    OP_SADD_B   = 5'd8,
    OP_SADD_W   = 5'd9,
    OP_SSUB_B   = 5'd10,
    OP_SSUB_W   = 5'd11,
    OP_UADD_B   = 5'd12,
    OP_UADD_W   = 5'd13,
    OP_USUB_B   = 5'd14,
    OP_USUB_W   = 5'd15,
    OP_UMIN_B   = 5'd16,
    OP_UMAX_B   = 5'd17,
    OP_SMIN_W   = 5'd18,
    OP_SMAX_W   = 5'd19,
    OP_AVG_B    = 5'd20,
    OP_AVG_W    = 5'd21,
    OP_MULLO_W  = 5'd22,
    OP_MULHS_W  = 5'd23,
    OP_MULHU_W  = 5'd24,
    OP_MADD_W   = 5'd25,
    OP_SAD_B    = 5'd26
  } op_t;

  localparam int unsigned NUM_LANES = 4;

  typedef struct packed {
    logic [15:0] res;
    logic [31:0] prod;
    logic [7:0]  sad_lo;
    logic [7:0]  sad_hi;
  } lane_out_t;

endpackage

>>> sv/pia_lane.sv
`timescale 1ns / 1ps
module pia_lane
  import pia_pkg::*;
(
  input  logic [4:0]  op,
  input  logic [15:0] a,
  input  logic [15:0] b,
  output lane_out_t   lo
);

  logic [8:0]  sb0, sb1, db0, db1;
  logic [16:0] sw, dw;
  logic [7:0]  r0, r1;
  logic [15:0] rw;
  logic signed [8:0]  ss0, ss1, sd0, sd1;
  logic signed [16:0] ssw, sdw;
  logic signed [16:0] ma, mb;
  logic signed [33:0] mp;
  logic [7:0]  ad0, ad1;

  function automatic logic [7:0] sat8s(input logic signed [8:0] v);
    if (v > 9'sd127) return 8'h7f;
    else if (v < -9'sd128) return 8'h80;
    else return v[7:0];
  endfunction

  function automatic logic [15:0] sat16s(input logic signed [16:0] v);
    if (v > 17'sd32767) return 16'h7fff;
    else if (v < -17'sd32768) return 16'h8000;
    else return v[15:0];
  endfunction

  always_comb begin
    sb0 = {1'b0, a[7:0]} + {1'b0, b[7:0]};
    sb1 = {1'b0, a[15:8]} + {1'b0, b[15:8]};
    db0 = {1'b0, a[7:0]} - {1'b0, b[7:0]};
    db1 = {1'b0, a[15:8]} - {1'b0, b[15:8]};
    sw  = {1'b0, a} + {1'b0, b};
    dw  = {1'b0, a} - {1'b0, b};
    ss0 = $signed({a[7], a[7:0]}) + $signed({b[7], b[7:0]});
    ss1 = $signed({a[15], a[15:8]}) + $signed({b[15], b[15:8]});
    sd0 = $signed({a[7], a[7:0]}) - $signed({b[7], b[7:0]});
    sd1 = $signed({a[15], a[15:8]}) - $signed({b[15], b[15:8]});
    ssw = $signed({a[15], a}) + $signed({b[15], b});
    sdw = $signed({a[15], a}) - $signed({b[15], b});
    ma  = (op == OP_MULHU_W) ? $signed({1'b0, a}) : $signed({a[15], a});
    mb  = (op == OP_MULHU_W) ? $signed({1'b0, b}) : $signed({b[15], b});
    mp  = ma * mb;
    ad0 = db0[8] ? (b[7:0] - a[7:0]) : db0[7:0];
    ad1 = db1[8] ? (b[15:8] - a[15:8]) : db1[7:0];
    r0 = 8'h00;
    r1 = 8'h00;
    rw = 16'h0000;
    unique case (op)
      OP_ADD_B:   rw = {sb1[7:0], sb0[7:0]};
      OP_ADD_W:   rw = sw[15:0];
      OP_SUB_B:   rw = {db1[7:0], db0[7:0]};
      OP_SUB_W:   rw = dw[15:0];
      OP_SADD_B:  rw = {sat8s(ss1), sat8s(ss0)};
      OP_SADD_W:  rw = sat16s(ssw);
      OP_SSUB_B:  rw = {sat8s(sd1), sat8s(sd0)};
      OP_SSUB_W:  rw = sat16s(sdw);
      OP_UADD_B: begin
        r0 = sb0[8] ? 8'hff : sb0[7:0];
        r1 = sb1[8] ? 8'hff : sb1[7:0];
        rw = {r1, r0};
      end
      OP_UADD_W:  rw = sw[16] ? 16'hffff : sw[15:0];
      OP_USUB_B: begin
        r0 = db0[8] ? 8'h00 : db0[7:0];
        r1 = db1[8] ? 8'h00 : db1[7:0];
        rw = {r1, r0};
      end
      OP_USUB_W:  rw = dw[16] ? 16'h0000 : dw[15:0];
      OP_UMIN_B:  rw = {db1[8] ? a[15:8] : b[15:8], db0[8] ? a[7:0] : b[7:0]};
      OP_UMAX_B:  rw = {db1[8] ? b[15:8] : a[15:8], db0[8] ? b[7:0] : a[7:0]};
      OP_SMIN_W:  rw = sdw[16] ? a : b;
      OP_SMAX_W:  rw = sdw[16] ? b : a;
      OP_AVG_B: begin
        r0 = 8'((sb0 + 9'd1) >> 1);
        r1 = 8'((sb1 + 9'd1) >> 1);
        rw = {r1, r0};
      end
      OP_AVG_W:   rw = 16'((sw + 17'd1) >> 1);
      OP_MULLO_W: rw = mp[15:0];
      OP_MULHS_W: rw = mp[31:16];
      OP_MULHU_W: rw = mp[31:16];
      default:    rw = 16'h0000;
    endcase
    lo.res    = rw;
    lo.prod   = mp[31:0];
    lo.sad_lo = ad0;
    lo.sad_hi = ad1;
  end

endmodule

>>> sv/pia_merge.sv
`timescale 1ns / 1ps
module pia_merge
  import pia_pkg::*;
(
  input  logic [4:0]                 op,
  input  logic [63:0]                a,
  input  logic [63:0]                b,
  input  lane_out_t [NUM_LANES-1:0]  lanes,
  output logic [63:0]                res
);

  logic [63:0] lw;
  logic [31:0] d_add0, d_add1, d_sub0, d_sub1;
  logic [63:0] q_add, q_sub;
  logic [10:0] sad;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) lw[i*16 +: 16] = lanes[i].res;
    d_add0 = a[31:0] + b[31:0];
    d_add1 = a[63:32] + b[63:32];
    d_sub0 = a[31:0] - b[31:0];
    d_sub1 = a[63:32] - b[63:32];
    q_add  = a + b;
    q_sub  = a - b;
    sad = 11'd0;
    for (int i = 0; i < NUM_LANES; i++)
      sad = sad + 11'(lanes[i].sad_lo) + 11'(lanes[i].sad_hi);
    unique case (op)
      OP_ADD_D: res = {d_add1, d_add0};
      OP_ADD_Q: res = q_add;
      OP_SUB_D: res = {d_sub1, d_sub0};
      OP_SUB_Q: res = q_sub;
      OP_MADD_W: res = {lanes[3].prod + lanes[2].prod, lanes[1].prod + lanes[0].prod};
      OP_SAD_B: res = {53'd0, sad};
      default:  res = (op > OP_SAD_B) ? 64'd0 : lw;
    endcase
  end

endmodule

>>> sv/packed_integer_alu.sv
`timescale 1ns / 1ps
// channel   ports                                              handshake
// input     in_operation, in_left_slice, in_right_slice,       start / busy
//           in_last_slice
// result    out_result_slice, out_result_last                  out_valid strobe
//
// one transaction per cycle; the result is registered and appears in the cycle after start
// busy is tied low: four 16-bit lanes and the merge stage are combinational
// synchronous active-low reset clears the strobe
// the receiver cannot stall; every result is shown for exactly one cycle
module packed_integer_alu
  import pia_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  in_operation,
  input  logic [63:0] in_left_slice,
  input  logic [63:0] in_right_slice,
  input  logic        in_last_slice,
  output logic        out_valid,
  output logic [63:0] out_result_slice,
  output logic        out_result_last
);

  lane_out_t [NUM_LANES-1:0] lanes;
  logic [63:0] res_nxt;
  logic        valid_r;
  logic [63:0] res_r;
  logic        last_r;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    pia_lane u_lane (
      .op (in_operation),
      .a  (in_left_slice[g*16 +: 16]),
      .b  (in_right_slice[g*16 +: 16]),
      .lo (lanes[g])
    );
  end

  pia_merge u_merge (
    .op    (in_operation),
    .a     (in_left_slice),
    .b     (in_right_slice),
    .lanes (lanes),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      res_r  <= res_nxt;
      last_r <= in_last_slice;
    end
  end

  assign busy             = 1'b0;
  assign out_valid        = valid_r;
  assign out_result_slice = res_r;
  assign out_result_last  = last_r;

endmodule

>>> sim/pia_checker.sv
`timescale 1ns / 1ps
module pia_checker
  import pia_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [4:0]  in_operation,
  input  logic [63:0] in_left_slice,
  input  logic [63:0] in_right_slice,
  input  logic        in_last_slice,
  input  logic        out_valid,
  input  logic [63:0] out_result_slice,
  input  logic        out_result_last,
  output int          fail_count,
  output int          pending_count
);

  typedef struct {
    logic [63:0] slice;
    logic        last;
  } slice_result_t;

  slice_result_t result_queue[$];

  function automatic int sx8(logic [7:0] v);
    return int'($signed(v));
  endfunction

  function automatic int sx16(logic [15:0] v);
    return int'($signed(v));
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [63:0] alu_slice(logic [4:0] opc, logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    logic [7:0]  xa, xb;
    logic [15:0] wa, wb;
    logic [31:0] pr;
    int          s0, s1, acc;
    r = '0;
    case (opc)
      OP_ADD_Q: r = a + b;
      OP_SUB_Q: r = a - b;
      OP_ADD_D, OP_SUB_D:
        for (int i = 0; i < 2; i++)
          r[i*32 +: 32] = (opc == OP_ADD_D) ? a[i*32 +: 32] + b[i*32 +: 32]
                                            : a[i*32 +: 32] - b[i*32 +: 32];
      OP_MADD_W:
        for (int i = 0; i < 2; i++) begin
          s0 = sx16(a[i*32 +: 16]) * sx16(b[i*32 +: 16]);
          s1 = sx16(a[i*32+16 +: 16]) * sx16(b[i*32+16 +: 16]);
          pr = 32'(s0) + 32'(s1);
          r[i*32 +: 32] = pr;
        end
      OP_SAD_B: begin
        acc = 0;
        for (int i = 0; i < 8; i++) begin
          xa = a[i*8 +: 8];
          xb = b[i*8 +: 8];
          acc += (xa > xb) ? int'(xa) - int'(xb) : int'(xb) - int'(xa);
        end
        r[15:0] = 16'(acc);
      end
      OP_ADD_B, OP_SUB_B, OP_SADD_B, OP_SSUB_B, OP_UADD_B, OP_USUB_B,
      OP_UMIN_B, OP_UMAX_B, OP_AVG_B:
        for (int i = 0; i < 8; i++) begin
          xa = a[i*8 +: 8];
          xb = b[i*8 +: 8];
          case (opc)
            OP_ADD_B:  r[i*8 +: 8] = xa + xb;
            OP_SUB_B:  r[i*8 +: 8] = xa - xb;
            OP_SADD_B: r[i*8 +: 8] = 8'(clamp(sx8(xa) + sx8(xb), -128, 127));
            OP_SSUB_B: r[i*8 +: 8] = 8'(clamp(sx8(xa) - sx8(xb), -128, 127));
            OP_UADD_B: r[i*8 +: 8] = 8'(clamp(int'(xa) + int'(xb), 0, 255));
            OP_USUB_B: r[i*8 +: 8] = 8'(clamp(int'(xa) - int'(xb), 0, 255));
            OP_UMIN_B: r[i*8 +: 8] = (xa < xb) ? xa : xb;
            OP_UMAX_B: r[i*8 +: 8] = (xa > xb) ? xa : xb;
            default:   r[i*8 +: 8] = 8'((int'(xa) + int'(xb) + 1) >> 1);
          endcase
        end
      OP_ADD_W, OP_SUB_W, OP_SADD_W, OP_SSUB_W, OP_UADD_W, OP_USUB_W, OP_SMIN_W,
      OP_SMAX_W, OP_AVG_W, OP_MULLO_W, OP_MULHS_W, OP_MULHU_W:
        for (int i = 0; i < 4; i++) begin
          wa = a[i*16 +: 16];
          wb = b[i*16 +: 16];
          case (opc)
            OP_ADD_W:   r[i*16 +: 16] = wa + wb;
            OP_SUB_W:   r[i*16 +: 16] = wa - wb;
            OP_SADD_W:  r[i*16 +: 16] = 16'(clamp(sx16(wa) + sx16(wb), -32768, 32767));
            OP_SSUB_W:  r[i*16 +: 16] = 16'(clamp(sx16(wa) - sx16(wb), -32768, 32767));
            OP_UADD_W:  r[i*16 +: 16] = 16'(clamp(int'(wa) + int'(wb), 0, 65535));
            OP_USUB_W:  r[i*16 +: 16] = 16'(clamp(int'(wa) - int'(wb), 0, 65535));
            OP_SMIN_W:  r[i*16 +: 16] = (sx16(wa) < sx16(wb)) ? wa : wb;
            OP_SMAX_W:  r[i*16 +: 16] = (sx16(wa) > sx16(wb)) ? wa : wb;
            OP_AVG_W:   r[i*16 +: 16] = 16'((int'(wa) + int'(wb) + 1) >> 1);
            OP_MULLO_W: begin
              pr = 32'(wa) * 32'(wb);
              r[i*16 +: 16] = pr[15:0];
            end
            OP_MULHS_W: begin
              pr = 32'(sx16(wa) * sx16(wb));
              r[i*16 +: 16] = pr[31:16];
            end
            default: begin
              pr = 32'(wa) * 32'(wb);
              r[i*16 +: 16] = pr[31:16];
            end
          endcase
        end
      default: r = '0;
    endcase
    return r;
  endfunction

  initial fail_count = 0;
  initial pending_count = 0;

  always @(posedge clk) begin
    slice_result_t want;
    int            errs;
    errs = 0;
    if (rst_n && out_valid) begin
      if (result_queue.size() == 0) begin
        $display("%0t: unexpected result slice %h last %b", $time, out_result_slice,
                 out_result_last);
        errs++;
      end else begin
        want = result_queue.pop_front();
        if (out_result_slice !== want.slice) begin
          $display("%0t: result_slice expected %h actual %h", $time, want.slice,
                   out_result_slice);
          errs++;
        end
        if (out_result_last !== want.last) begin
          $display("%0t: result_last expected %b actual %b", $time, want.last,
                   out_result_last);
          errs++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      want.slice = alu_slice(in_operation, in_left_slice, in_right_slice);
      want.last  = in_last_slice;
      result_queue.push_back(want);
    end
    fail_count    <= fail_count + errs;
    pending_count <= result_queue.size();
  end

endmodule

>>> sim/tb_packed_integer_alu.sv
`timescale 1ns / 1ps
module tb_packed_integer_alu;
  import pia_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [4:0]  in_operation;
  logic [63:0] in_left_slice;
  logic [63:0] in_right_slice;
  logic        in_last_slice;
  logic        out_valid;
  logic [63:0] out_result_slice;
  logic        out_result_last;
  int          fail_count;
  int          pending_count;
  int          cycle_count;

  localparam int CYCLE_LIMIT = 200000;

  packed_integer_alu dut (.*);

  pia_checker checker_inst (.*);

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("packed_integer_alu test failed");
      $finish;
    end
  end

  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = {8{8'h80}};
      3: v = {8{8'h7f}};
      4: v = {4{16'h8000}};
      5: v = {4{16'h7fff}};
      6: v = v & {8{8'h81}};
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_slice(logic [4:0] opc, logic [63:0] a, logic [63:0] b, logic last,
                            bit allow_idle);
    while (allow_idle && $urandom_range(0, 99) < 36) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_operation   <= opc;
    in_left_slice  <= a;
    in_right_slice <= b;
    in_last_slice  <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    int n;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_operation   = '0;
    in_left_slice  = '0;
    in_right_slice = '0;
    in_last_slice  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int op = 0; op < 32; op++)
      send_slice(5'(op), {$urandom, $urandom}, {$urandom, $urandom}, op[0], 1'b0);
    send_slice(OP_MADD_W, {4{16'h8000}}, {4{16'h8000}}, 1'b1, 1'b0);
    send_slice(OP_SAD_B, '1, '0, 1'b0, 1'b0);
    send_slice(OP_SADD_B, {8{8'h7f}}, {8{8'h7f}}, 1'b1, 1'b0);
    send_slice(OP_SSUB_W, {4{16'h8000}}, {4{16'h7fff}}, 1'b0, 1'b1);

    n = 0;
    while (n < 1900) begin
      send_slice(5'($urandom_range(0, 99) < 95 ? $urandom_range(0, 26) : $urandom_range(27, 31)),
                 pick_operand(), pick_operand(), 1'($urandom), !(n >= 600 && n < 900));
      n++;
    end
    start <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("packed_integer_alu test passed");
    end else begin
      $display("packed_integer_alu test failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/pia_pkg.sv
sv/pia_lane.sv
sv/pia_merge.sv
sv/packed_integer_alu.sv
sim/pia_checker.sv
sim/tb_packed_integer_alu.sv
